// ===== src/lspe_pkg.sv =====
// ============================================================================
// lspe_pkg
// Shared types, command codes and arithmetic helpers for the LED strip
// pulse encoder.
// ============================================================================
`default_nettype none

package lspe_pkg;

  // Command codes as seen on the input channel
  localparam logic [2:0] CMD_SET   = 3'd0;
  localparam logic [2:0] CMD_FILL  = 3'd1;
  localparam logic [2:0] CMD_CLEAR = 3'd2;
  localparam logic [2:0] CMD_START = 3'd3;
  localparam logic [2:0] CMD_PULSE = 3'd4;
  // Internal op for any code that means nothing
  localparam logic [2:0] OP_NOP    = 3'd7;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_PERIOD = 2'd0;
  localparam logic [1:0] REG_BRIGHT = 2'd1;
  localparam logic [1:0] REG_COUNT  = 2'd2;

  localparam logic [15:0] PERIOD_RST = 16'd89;
  localparam logic [7:0]  BRIGHT_RST = 8'd255;
  localparam logic [8:0]  COUNT_RST  = 9'd256;

  // x / 3 == (x * DIV3_MUL) >> DIV3_SHIFT, exact for x below 2**19
  localparam int          DIV3_SHIFT = 19;
  localparam logic [17:0] DIV3_MUL   = 18'd174763;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] led_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_item_t;

  typedef struct packed {
    logic [15:0] pulse_width;
    logic        pulse_valid;
    logic        last_pulse;
    logic        busy_res;
    logic        rejected;
  } out_item_t;

  // Classified command as it travels from front to back
  typedef struct packed {
    logic [2:0]  op;
    logic        rej;
    logic [7:0]  idx;
    logic [23:0] grb;
  } cmd_t;

  // x / 255 for x up to 255*255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] y;
    y = 17'(x) + 17'd1 + 17'(x[15:8]);
    return y[15:8];
  endfunction

endpackage

`default_nettype wire

// ===== src/led_strip_pulse_encoder.sv =====
// ============================================================================
// led_strip_pulse_encoder
// Color store and PWM compare value generator for an addressable LED strip.
// ============================================================================
// Usage:
//   Input: drive in_data with start; the command is taken at an edge where
//   start is high and busy is low. Commands go to a two-entry queue, so busy
//   only rises when the queue is full or the store is being zeroed.
//   Output: every command gives one result, shown on out_res for exactly one
//   cycle with out_valid high. The receiver cannot hold results off.
//   set_led, start_send, an idle or reset-slot pulse request and unknown
//   codes answer from the execute state; a pulse request within an LED
//   goes through the divide by 3, and the first bit of an LED goes through
//   store read, scaling multiply, divide by 255 and divide by 3; fill and
//   clear walk the store and write one entry per cycle.
//   The back end handles one command at a time; the queue lets the next
//   command be taken while it works.
//   Reset: registers return to their defaults, then a clearing pass zeroes
//   all LED_MAX store entries with busy high. APB writes work throughout.
//   Configuration is written via APB (pready tied high); the user must write
//   it only while no command is pending, which the block itself does not enforce.
// ============================================================================
`default_nettype none

module led_strip_pulse_encoder import lspe_pkg::*; #(
  parameter int LED_MAX     = 256,
  parameter int RESET_SLOTS = 80
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  output out_item_t        out_res,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int CW = $clog2(LED_MAX + 1);
  localparam int AW = (LED_MAX > 1) ? $clog2(LED_MAX) : 1;

  logic [15:0]   period_r, period_nxt;
  logic [7:0]    bright_r, bright_nxt;
  logic [8:0]    count_r, count_nxt;
  logic          wr_en;
  logic [CW-1:0] count_use;

  logic q_push, q_pop, q_valid, q_ready, init_busy;
  cmd_t push_data, head_data;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Number of LEDs in use, capped at the store depth
  assign count_use = (32'(count_r) < 32'(LED_MAX)) ? CW'(count_r) : CW'(LED_MAX);

  always_comb begin
    period_nxt = period_r;
    bright_nxt = bright_r;
    count_nxt  = count_r;
    if (wr_en) begin
      unique case (paddr[3:2])
        REG_PERIOD: period_nxt = pwdata[15:0];
        REG_BRIGHT: bright_nxt = pwdata[7:0];
        REG_COUNT:  count_nxt  = pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_PERIOD: prdata = {16'd0, period_r};
      REG_BRIGHT: prdata = {24'd0, bright_r};
      REG_COUNT:  prdata = {23'd0, count_r};
      default:    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RST;
      bright_r <= BRIGHT_RST;
      count_r  <= COUNT_RST;
    end else begin
      period_r <= period_nxt;
      bright_r <= bright_nxt;
      count_r  <= count_nxt;
    end
  end

  lspe_front #(
    .CW (CW)
  ) u_front (
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .count     (count_use),
    .q_ready   (q_ready),
    .init_busy (init_busy),
    .q_push    (q_push),
    .q_data    (push_data)
  );

  lspe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_data    (head_data),
    .q_ready   (q_ready)
  );

  lspe_back #(
    .LED_MAX     (LED_MAX),
    .RESET_SLOTS (RESET_SLOTS),
    .CW          (CW),
    .AW          (AW)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_data       (head_data),
    .q_pop        (q_pop),
    .count        (count_use),
    .timer_period (period_r),
    .brightness   (bright_r),
    .init_busy    (init_busy),
    .out_valid    (out_valid),
    .out_res      (out_res)
  );

endmodule

`default_nettype wire

// ===== src/lspe_front.sv =====
// ============================================================================
// lspe_front
// Input handshake and command classification: decodes the command, packs
// the GRB word and checks the LED index against the count in use.
// ============================================================================
`default_nettype none

module lspe_front import lspe_pkg::*; #(
  parameter int CW = 9
) (
  input  wire logic          start,
  output logic               busy,
  input  wire in_item_t      in_data,
  input  wire logic [CW-1:0] count,
  input  wire logic          q_ready,
  input  wire logic          init_busy,
  output logic               q_push,
  output cmd_t               q_data
);

  logic [2:0] op;

  assign busy   = init_busy || !q_ready;
  assign q_push = start && !busy;

  always_comb begin
    unique case (in_data.command)
      CMD_SET, CMD_FILL, CMD_CLEAR, CMD_START, CMD_PULSE: op = in_data.command;
      default: op = OP_NOP;
    endcase
  end

  always_comb begin
    q_data.op  = op;
    q_data.rej = (op == CMD_SET) &&
                 ({{CW{1'b0}}, in_data.led_index} >= {8'd0, count});
    q_data.idx = in_data.led_index;
    q_data.grb = {in_data.green, in_data.red, in_data.blue};
  end

endmodule

`default_nettype wire

// ===== src/lspe_queue.sv =====
// ============================================================================
// lspe_queue
// Two-entry command queue between the front and the back.
// ============================================================================
`default_nettype none

module lspe_queue import lspe_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_data,
  input  wire logic pop,
  output logic      q_valid,
  output cmd_t      q_data,
  output logic      q_ready
);

  cmd_t       ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;

  assign q_valid = (fill_r != 2'd0);
  assign q_ready = (fill_r != 2'd2);
  assign q_data  = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== src/lspe_back.sv =====
// ============================================================================
// lspe_back
// Command execution: color store, store sweeps, send sequencing and pulse
// width generation.
// ============================================================================
`default_nettype none

module lspe_back import lspe_pkg::*; #(
  parameter int LED_MAX     = 256,
  parameter int RESET_SLOTS = 80,
  parameter int CW          = 9,
  parameter int AW          = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  wire cmd_t          q_data,
  output logic               q_pop,
  input  wire logic [CW-1:0] count,
  input  wire logic [15:0]   timer_period,
  input  wire logic [7:0]    brightness,
  output logic               init_busy,
  output logic               out_valid,
  output out_item_t          out_res
);

  localparam int RW = $clog2(RESET_SLOTS + 1);

  localparam logic [3:0] S_INIT = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_EXEC = 4'd2;
  localparam logic [3:0] S_WALK = 4'd3;
  localparam logic [3:0] S_RD   = 4'd4;
  localparam logic [3:0] S_MUL  = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_WID  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [23:0] mem [LED_MAX];
  logic [23:0] rdata_r;
  logic        mem_we;
  logic [AW-1:0] mem_waddr;
  logic [23:0] mem_wdata;

  logic [3:0]    st_r, st_nxt;
  cmd_t          cur_r, cur_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic          sending_r, sending_nxt;
  logic [CW-1:0] led_pos_r, led_pos_nxt;
  logic [4:0]    bit_pos_r, bit_pos_nxt;
  logic [RW-1:0] slot_r, slot_nxt;
  logic [23:0]   shift_r, shift_nxt;
  logic [15:0]   pg_r, pg_nxt, pr_r, pr_nxt, pb_r, pb_nxt;
  logic [35:0]   wprod_r, wprod_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_res_r, out_res_nxt;

  logic [16:0]   total;
  logic [17:0]   num;
  logic [RW-1:0] slot_inc;

  assign init_busy = (st_r == S_INIT);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  assign total    = 17'(timer_period) + 17'd1;
  assign num      = shift_r[23] ? {total, 1'b0} : {1'b0, total};
  assign slot_inc = slot_r + RW'(1);

  always_comb begin
    st_nxt        = st_r;
    cur_nxt       = cur_r;
    ptr_nxt       = ptr_r;
    sending_nxt   = sending_r;
    led_pos_nxt   = led_pos_r;
    bit_pos_nxt   = bit_pos_r;
    slot_nxt      = slot_r;
    shift_nxt     = shift_r;
    pg_nxt        = pg_r;
    pr_nxt        = pr_r;
    pb_nxt        = pb_r;
    wprod_nxt     = wprod_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = ptr_r[AW-1:0];
    mem_wdata     = '0;

    unique case (st_r)
      S_INIT: begin
        // Zero the whole store once after reset
        mem_we = 1'b1;
        if (ptr_r == CW'(LED_MAX - 1)) begin
          ptr_nxt = '0;
          st_nxt  = S_IDLE;
        end else begin
          ptr_nxt = ptr_r + CW'(1);
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cur_nxt = q_data;
          st_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        out_res_nxt          = '0;
        out_res_nxt.busy_res = sending_r;
        st_nxt               = S_IDLE;
        unique case (cur_r.op)
          CMD_SET: begin
            out_valid_nxt        = 1'b1;
            out_res_nxt.rejected = cur_r.rej;
            mem_we               = !cur_r.rej;
            mem_waddr            = cur_r.idx[AW-1:0];
            mem_wdata            = cur_r.grb;
          end
          CMD_FILL, CMD_CLEAR: begin
            ptr_nxt = '0;
            if (count == '0) begin
              out_valid_nxt = 1'b1;
            end else begin
              st_nxt = S_WALK;
            end
          end
          CMD_START: begin
            out_valid_nxt = 1'b1;
            if (sending_r) begin
              out_res_nxt.rejected = 1'b1;
            end else begin
              sending_nxt          = 1'b1;
              led_pos_nxt          = '0;
              bit_pos_nxt          = '0;
              slot_nxt             = '0;
              shift_nxt            = '0;
              out_res_nxt.busy_res = 1'b1;
            end
          end
          CMD_PULSE: begin
            if (!sending_r) begin
              out_valid_nxt = 1'b1;
            end else if (led_pos_r < count) begin
              st_nxt = (bit_pos_r == 5'd0) ? S_RD : S_WID;
            end else begin
              // Reset slot: zero width, flag the final one
              out_valid_nxt           = 1'b1;
              out_res_nxt.pulse_valid = 1'b1;
              slot_nxt                = slot_inc;
              if (slot_inc >= RW'(RESET_SLOTS)) begin
                sending_nxt            = 1'b0;
                out_res_nxt.last_pulse = 1'b1;
                out_res_nxt.busy_res   = 1'b0;
              end
            end
          end
          default: begin
            out_valid_nxt = 1'b1;
          end
        endcase
      end
      S_WALK: begin
        mem_we    = 1'b1;
        mem_wdata = (cur_r.op == CMD_FILL) ? cur_r.grb : 24'd0;
        ptr_nxt   = ptr_r + CW'(1);
        if (ptr_r == count - CW'(1)) begin
          out_valid_nxt = 1'b1;
          st_nxt        = S_IDLE;
        end
      end
      S_RD: begin
        // Store read at led_pos_r lands in rdata_r
        st_nxt = S_MUL;
      end
      S_MUL: begin
        pg_nxt = 16'(rdata_r[23:16]) * 16'(brightness);
        pr_nxt = 16'(rdata_r[15:8]) * 16'(brightness);
        pb_nxt = 16'(rdata_r[7:0]) * 16'(brightness);
        st_nxt = S_DIV;
      end
      S_DIV: begin
        shift_nxt = {div255(pg_r), div255(pr_r), div255(pb_r)};
        st_nxt    = S_WID;
      end
      S_WID: begin
        wprod_nxt = {18'd0, num} * {18'd0, DIV3_MUL};
        st_nxt    = S_OUT;
      end
      S_OUT: begin
        out_valid_nxt           = 1'b1;
        out_res_nxt             = '0;
        out_res_nxt.pulse_width = wprod_r[DIV3_SHIFT+15:DIV3_SHIFT];
        out_res_nxt.pulse_valid = 1'b1;
        out_res_nxt.busy_res    = 1'b1;
        shift_nxt               = {shift_r[22:0], 1'b0};
        if (bit_pos_r == 5'd23) begin
          bit_pos_nxt = '0;
          led_pos_nxt = led_pos_r + CW'(1);
        end else begin
          bit_pos_nxt = bit_pos_r + 5'd1;
        end
        st_nxt = S_IDLE;
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_INIT;
      ptr_r       <= '0;
      sending_r   <= 1'b0;
      led_pos_r   <= '0;
      bit_pos_r   <= '0;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      ptr_r       <= ptr_nxt;
      sending_r   <= sending_nxt;
      led_pos_r   <= led_pos_nxt;
      bit_pos_r   <= bit_pos_nxt;
      slot_r      <= slot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    shift_r   <= shift_nxt;
    pg_r      <= pg_nxt;
    pr_r      <= pr_nxt;
    pb_r      <= pb_nxt;
    wprod_r   <= wprod_nxt;
    out_res_r <= out_res_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[led_pos_r[AW-1:0]];
  end

endmodule

`default_nettype wire

// ===== src/lspe_checker.sv =====
// ============================================================================
// lspe_checker
// Port-level checks on the result channel of the LED strip pulse encoder.
// ============================================================================
`default_nettype none

module lspe_checker import lspe_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire out_item_t out_res,
  input wire logic      pready
);

  // The final reset slot belongs to a send and ends it
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.last_pulse |-> out_res.pulse_valid && !out_res.busy_res)
    else $error("last pulse without valid pulse or with busy still set");

  // A non-pulse result carries no width and no last flag
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_res.pulse_valid |-> out_res.pulse_width == 16'd0 && !out_res.last_pulse)
    else $error("width or last flag on a non-pulse result");

  // A rejected transaction is never a pulse
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.rejected |-> !out_res.pulse_valid)
    else $error("rejected transaction reported as a pulse");

  // Reset drops the result strobe
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe after reset");

  assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind led_strip_pulse_encoder lspe_checker u_lspe_checker (.*);

`default_nettype wire

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// LED strip pulse encoder testbench
// Drives commands and register writes into the encoder and predicts the
// reply to each command: color store writes, rejects, send arming and the
// compare value of every pulse slot. Replies are checked field by field, in
// order, against the prediction. A directed opening is followed by random
// phases, each under its own register setting.
// ----------------------------------------------------------------------------
module testbench import lspe_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          LEDS        = 256;
  localparam int          END_SLOTS   = 80;
  localparam int          RANDOM_CMDS = 900;
  localparam logic [2:0]  CMD_RSVD5   = 3'd5;
  localparam logic [2:0]  CMD_RSVD6   = 3'd6;
  localparam logic [2:0]  CMD_RSVD7   = 3'd7;

  class strip_scoreboard;
    bit [23:0]   grb_store [LEDS];
    bit          frame_active;
    int unsigned led_ptr, bit_ptr, tail_slots;
    bit [23:0]   grb_shift;
    bit [15:0]   period_reg = PERIOD_RST;
    bit [7:0]    bright_reg = BRIGHT_RST;
    bit [8:0]    count_reg  = COUNT_RST;
    out_item_t   replies_due [$];
    int unsigned errors;

    function void write_register(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_PERIOD: period_reg = value[15:0];
        REG_BRIGHT: bright_reg = value[7:0];
        REG_COUNT:  count_reg  = value[8:0];
        default: ;
      endcase
    endfunction

    function int unsigned leds_active();
      return (count_reg < LEDS) ? count_reg : LEDS;
    endfunction

    function bit [7:0] dim(bit [7:0] c);
      if (bright_reg == 8'hff) return c;
      return 8'((int'(c) * int'(bright_reg)) / 255);
    endfunction

    // Advance the strip state by one accepted command and queue its reply.
    function void note_command(in_item_t cmd);
      out_item_t   reply;
      int unsigned n, total, w;
      bit [23:0]   word;
      reply = '0;
      n = leds_active();
      case (cmd.command)
        CMD_SET: begin
          if (cmd.led_index < n) grb_store[cmd.led_index] = {cmd.green, cmd.red, cmd.blue};
          else reply.rejected = 1'b1;
        end
        CMD_FILL: begin
          for (int i = 0; i < n; i++) grb_store[i] = {cmd.green, cmd.red, cmd.blue};
        end
        CMD_CLEAR: begin
          for (int i = 0; i < n; i++) grb_store[i] = '0;
        end
        CMD_START: begin
          if (frame_active) begin
            reply.rejected = 1'b1;
          end else begin
            frame_active = 1'b1;
            led_ptr      = 0;
            bit_ptr      = 0;
            tail_slots   = 0;
            grb_shift    = '0;
          end
        end
        CMD_PULSE: begin
          if (frame_active) begin
            reply.pulse_valid = 1'b1;
            if (led_ptr < n) begin
              total = int'(period_reg) + 1;
              // latch and scale the LED word on its first bit only
              if (bit_ptr == 0) begin
                word      = grb_store[led_ptr];
                grb_shift = {dim(word[23:16]), dim(word[15:8]), dim(word[7:0])};
              end
              w = grb_shift[23] ? (total * 2) / 3 : total / 3;
              reply.pulse_width = w[15:0];
              grb_shift = grb_shift << 1;
              bit_ptr++;
              if (bit_ptr >= 24) begin
                bit_ptr = 0;
                led_ptr++;
              end
            end else begin
              tail_slots++;
              if (tail_slots >= END_SLOTS) begin
                reply.last_pulse = 1'b1;
                frame_active     = 1'b0;
              end
            end
          end
        end
        default: ;
      endcase
      reply.busy_res = frame_active;
      replies_due.push_back(reply);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (replies_due.size() == 0) begin
        $error("reply with no command waiting: %p", got);
        errors++;
        return;
      end
      want = replies_due.pop_front();
      if (got.pulse_width !== want.pulse_width) begin
        $error("pulse_width: expected %0d, actual %0d", want.pulse_width, got.pulse_width);
        errors++;
      end
      if (got.pulse_valid !== want.pulse_valid) begin
        $error("pulse_valid: expected %0b, actual %0b", want.pulse_valid, got.pulse_valid);
        errors++;
      end
      if (got.last_pulse !== want.last_pulse) begin
        $error("last_pulse: expected %0b, actual %0b", want.last_pulse, got.last_pulse);
        errors++;
      end
      if (got.busy_res !== want.busy_res) begin
        $error("busy_res: expected %0b, actual %0b", want.busy_res, got.busy_res);
        errors++;
      end
      if (got.rejected !== want.rejected) begin
        $error("rejected: expected %0b, actual %0b", want.rejected, got.rejected);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_data;
  logic        out_valid;
  out_item_t   out_res;
  logic        psel, penable, pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  strip_scoreboard sb = new();
  bit              steady;
  int unsigned     cmds_sent;

  led_strip_pulse_encoder #(
    .LED_MAX     (LEDS),
    .RESET_SLOTS (END_SLOTS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_res   (out_res),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) sb.check_result(out_res);
  end

  function automatic in_item_t item_of(logic [2:0] cmd, logic [7:0] idx,
                                       logic [7:0] r, logic [7:0] g, logic [7:0] b);
    in_item_t it;
    it.command   = cmd;
    it.led_index = idx;
    it.red       = r;
    it.green     = g;
    it.blue      = b;
    return it;
  endfunction

  function automatic in_item_t rand_item(logic [2:0] cmd);
    return item_of(cmd, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endfunction

  // Store write: mostly an in-range set_led, sometimes fill or clear.
  function automatic in_item_t paint(int unsigned n);
    in_item_t    it;
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 7) begin
      it = rand_item(CMD_SET);
      if (n > 0 && roll < 6) it.led_index = 8'($urandom_range(0, n - 1));
    end else if (roll < 9) begin
      it = rand_item(CMD_FILL);
    end else begin
      it = rand_item(CMD_CLEAR);
    end
    return it;
  endfunction

  task automatic drop_start();
    @(negedge clk);
    start = 1'b0;
  endtask

  // Hold the command until the encoder takes it, then maybe idle a while.
  task automatic issue(input in_item_t cmd);
    int unsigned roll, gap;
    @(negedge clk);
    start   = 1'b1;
    in_data = cmd;
    do @(posedge clk); while (busy);
    sb.note_command(cmd);
    if (cmd.command <= CMD_PULSE) cmds_sent++;
    gap = 0;
    if (!steady) begin
      roll = $urandom_range(0, 99);
      if (roll >= 94) gap = $urandom_range(8, 40);
      else if (roll >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      drop_start();
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    drop_start();
    while (sb.replies_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_register(idx, value);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic run_phase(input int phase_no);
    logic [15:0] period;
    logic [7:0]  bright;
    logic [8:0]  cnt;
    int unsigned n, budget, roll;
    case (phase_no)
      0: begin
        period = 16'd0;     bright = 8'd0;   cnt = 9'd1;
      end
      1: begin
        period = 16'hffff;  bright = 8'd255; cnt = 9'd511;
      end
      2: begin
        period = 16'd2;     bright = 8'd1;   cnt = 9'd0;
      end
      default: begin
        roll   = $urandom_range(0, 5);
        period = (roll == 0) ? 16'd1 : (roll == 1) ? 16'hffff : 16'($urandom_range(0, 65535));
        roll   = $urandom_range(0, 5);
        bright = (roll == 0) ? 8'd254 : (roll == 1) ? 8'd255 : 8'($urandom_range(0, 255));
        roll   = $urandom_range(0, 15);
        if (roll == 0) cnt = 9'd256;
        else if (roll == 1) cnt = 9'($urandom_range(5, 511));
        else if (roll == 2) cnt = 9'd0;
        else cnt = 9'($urandom_range(1, 4));
      end
    endcase
    wait_idle();
    write_reg(REG_PERIOD, 32'(period));
    write_reg(REG_BRIGHT, 32'(bright));
    write_reg(REG_COUNT, 32'(cnt));
    steady = ($urandom_range(0, 3) == 0);
    n = (cnt < LEDS) ? cnt : LEDS;
    if (!sb.frame_active) begin
      repeat ($urandom_range(0, 4)) issue(paint(n));
      issue(rand_item(CMD_START));
    end
    // budget a whole send's worth of commands when the strip is short, else cut it off midway
    budget = (n <= 6) ? n * 24 + END_SLOTS + $urandom_range(0, 4) : $urandom_range(20, 80);
    for (int k = 0; k < budget; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 85) issue(rand_item(CMD_PULSE));
      else if (roll < 91) issue(paint(n));
      else issue(rand_item(3'($urandom_range(0, 7))));
    end
  endtask

  initial begin
    int phase_no;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    steady  = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    issue(rand_item(CMD_PULSE));
    issue(item_of(CMD_RSVD5, 8'hff, 8'hff, 8'hff, 8'hff));
    issue(item_of(CMD_RSVD6, 8'h00, 8'h00, 8'h00, 8'h00));
    issue(rand_item(CMD_RSVD7));
    issue(item_of(CMD_SET, 8'd0, 8'hff, 8'h00, 8'h80));
    issue(item_of(CMD_SET, 8'd255, 8'h00, 8'hff, 8'h01));
    issue(item_of(CMD_FILL, 8'd0, 8'h5a, 8'ha5, 8'hff));
    issue(item_of(CMD_CLEAR, 8'd0, 8'hff, 8'hff, 8'hff));
    issue(item_of(CMD_SET, 8'd1, 8'h01, 8'h80, 8'hff));
    wait_idle();
    write_reg(REG_PERIOD, 32'd89);
    write_reg(REG_BRIGHT, 32'd128);
    write_reg(REG_COUNT, 32'd2);
    issue(item_of(CMD_SET, 8'd2, 8'h11, 8'h22, 8'h33));
    issue(item_of(CMD_SET, 8'd255, 8'h11, 8'h22, 8'h33));
    issue(item_of(CMD_SET, 8'd0, 8'hff, 8'hff, 8'hff));
    issue(rand_item(CMD_START));
    issue(rand_item(CMD_START));
    repeat (3) issue(rand_item(CMD_PULSE));
    // store writes while the send runs show only in LEDs not yet begun
    issue(item_of(CMD_SET, 8'd1, 8'hc3, 8'h3c, 8'h0f));
    issue(rand_item(CMD_PULSE));
    issue(item_of(CMD_FILL, 8'd0, 8'h0f, 8'hf0, 8'haa));
    issue(rand_item(CMD_PULSE));
    issue(item_of(CMD_CLEAR, 8'd0, 8'h00, 8'h00, 8'h00));
    issue(rand_item(CMD_PULSE));

    cmds_sent = 0;
    phase_no  = 0;
    while (cmds_sent < RANDOM_CMDS) begin
      run_phase(phase_no);
      phase_no++;
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
